### hw/rtl/wcu8_pkg.sv
// ---------------------------------------------------------------------------
// Wide character to UTF-8 encoder package
// Shared types, constants and the byte encoding function.
// ---------------------------------------------------------------------------
`default_nettype none

package wcu8_pkg;

	localparam int PaddrW = 3;
	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// Register word index, taken from paddr[2].
	localparam logic RegUnitMode = 1'b0;

	// Unit modes.
	localparam logic Mode16 = 1'b0;
	localparam logic Mode32 = 1'b1;

	localparam logic [15:0] HiSurFirst = 16'hD800;
	localparam logic [15:0] HiSurLast  = 16'hDBFF;
	localparam logic [31:0] LoSurBase  = 32'h0000_DC00;
	localparam logic [31:0] HiSurBase  = 32'h0000_D800;
	localparam logic [31:0] PlaneOne   = 32'h0001_0000;

	// One code point waiting in the queue, with its byte count minus one.
	typedef struct packed {
		logic [31:0] cp;
		logic        str_end;
		logic [1:0]  nb_m1;
	} q_entry_t;

	// Byte idx of the UTF-8 sequence of cp that has nb_m1 + 1 bytes.
	function automatic logic [7:0] encode_byte(input logic [31:0] cp,
			input logic [1:0] nb_m1, input logic [1:0] idx);
		logic [1:0] pos;
		logic [5:0] sextet;
		logic [7:0] res;
		pos = nb_m1 - idx;
		case (pos)
			2'd0:    sextet = cp[5:0];
			2'd1:    sextet = cp[11:6];
			2'd2:    sextet = cp[17:12];
			2'd3:    sextet = cp[23:18];
			default: sextet = cp[5:0];
		endcase
		if (idx == 2'd0) begin
			case (nb_m1)
				2'd0:    res = cp[7:0];
				2'd1:    res = 8'hC0 | cp[13:6];
				2'd2:    res = 8'hE0 | cp[19:12];
				2'd3:    res = 8'hF0 | cp[25:18];
				default: res = cp[7:0];
			endcase
		end else begin
			res = {2'b10, sextet};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/wide_char_to_utf8_encoder.sv
// ---------------------------------------------------------------------------
// Wide character to UTF-8 encoder
// Converts UTF-16 or 32-bit code units into a UTF-8 byte stream.
// ---------------------------------------------------------------------------
// Each accepted input transaction carries one wide code unit and a flag
// marking the last unit of a string; the block answers with the unit's
// UTF-8 bytes, one output transaction per byte, flagging the last byte of
// each unit and the last byte of the string. In 16-bit mode (unit_mode = 0)
// a high surrogate that is not the final unit is held and combined, without
// checking, with the next unit; it produces no bytes itself. In 32-bit mode
// every unit is a code point, and values above 0x10FFFF still give four
// bytes with a truncated lead byte. The byte serializer emits one byte
// per cycle while the output is not stalled; a held surrogate is taken
// at the input and produces no bytes. The front end accepts a new unit
// every cycle while the two-entry code point queue has room, so input
// and output stall independently. With the serializer free, an accepted
// unit is written into the queue and its first byte then into the output
// register. A write to unit_mode drops any held surrogate; write it only
// while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module wide_char_to_utf8_encoder import wcu8_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration port.
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [PaddrW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	// Input channel.
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [31:0]       code_unit,
	input  wire logic              final_unit,
	// Output channel.
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [7:0]        utf8_byte,
	output logic                   last_of_run,
	output logic                   string_end
);

	logic     unit_mode_q;
	logic     mode_wr;
	logic     push;
	logic     pop;
	logic     q_empty;
	logic     q_full;
	q_entry_t push_data;
	q_entry_t head;

	// The port never waits. Only word 0 holds a register; writes to any
	// other word complete but change nothing. The low address bits are
	// ignored and do not affect decoding.
	assign pready  = 1'b1;
	assign mode_wr = psel && penable && pwrite && (paddr[2] == RegUnitMode);
	assign prdata  = (paddr[2] == RegUnitMode) ? {31'h0, unit_mode_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_mode_q <= Mode16;
		end else if (mode_wr) begin
			unit_mode_q <= pwdata[0];
		end
	end

	// The input side stalls only when the queue has no room, whether or not
	// the unit would be held as a surrogate.
	assign in_stall = q_full;

	// Front end: surrogate pairing and length classification.
	wcu8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_mode  (unit_mode_q),
		.clr        (mode_wr),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.push       (push),
		.push_data  (push_data)
	);

	// Code points waiting for the serializer.
	wcu8_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back end: one UTF-8 byte per cycle into the output register, unless the output stalls.
	wcu8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.utf8_byte   (utf8_byte),
		.last_of_run (last_of_run),
		.string_end  (string_end)
	);

endmodule

`default_nettype wire

### hw/rtl/wcu8_front.sv
// ---------------------------------------------------------------------------
// Encoder front end
// Accepts units, pairs surrogates and classifies the code point length.
// ---------------------------------------------------------------------------
`default_nettype none

module wcu8_front import wcu8_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        unit_mode,
	input  wire logic        clr,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [31:0] code_unit,
	input  wire logic        final_unit,
	output logic             push,
	output q_entry_t         push_data
);

	logic        pending_q;
	logic [15:0] held_q;
	logic [15:0] u16;
	logic        accept;
	logic        is_hi;
	logic        hold;
	logic [31:0] pair_cp;
	logic [31:0] cp;

	assign u16    = code_unit[15:0];
	assign accept = in_valid && !in_stall;
	assign is_hi  = (u16 >= HiSurFirst) && (u16 <= HiSurLast);
	assign hold   = (unit_mode == Mode16) && !pending_q && is_hi && !final_unit;

	// Unchecked pair combination, wrapping at 32 bits.
	assign pair_cp = PlaneOne + (({16'h0000, held_q} - HiSurBase) << 10)
		+ ({16'h0000, u16} - LoSurBase);

	always_comb begin
		if (unit_mode == Mode32) begin
			cp = code_unit;
		end else if (pending_q) begin
			cp = pair_cp;
		end else begin
			cp = {16'h0000, u16};
		end
		push_data.cp      = cp;
		push_data.str_end = final_unit;
		if (cp < 32'h80) begin
			push_data.nb_m1 = 2'd0;
		end else if (cp < 32'h800) begin
			push_data.nb_m1 = 2'd1;
		end else if (cp < 32'h1_0000) begin
			push_data.nb_m1 = 2'd2;
		end else begin
			push_data.nb_m1 = 2'd3;
		end
	end

	assign push = accept && !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			held_q    <= 16'h0000;
		end else if (clr) begin
			pending_q <= 1'b0;
			held_q    <= 16'h0000;
		end else if (accept && unit_mode == Mode16) begin
			if (hold) begin
				pending_q <= 1'b1;
				held_q    <= u16;
			end else if (pending_q) begin
				pending_q <= 1'b0;
				held_q    <= 16'h0000;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/wcu8_queue.sv
// ---------------------------------------------------------------------------
// Encoder code point queue
// Short register queue between the front end and the byte serializer.
// ---------------------------------------------------------------------------
`default_nettype none

module wcu8_queue import wcu8_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t push_data,
	input  wire logic     pop,
	output q_entry_t      head,
	output logic          empty,
	output logic          full
);

	q_entry_t               mem_q [QDepth];
	logic     [QPtrW-1:0]   wr_ptr_q;
	logic     [QPtrW-1:0]   rd_ptr_q;
	logic     [QCntW-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QCntW'(QDepth));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/wcu8_back.sv
// ---------------------------------------------------------------------------
// Encoder byte serializer
// Emits each queued code point's UTF-8 bytes, one per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module wcu8_back import wcu8_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire q_entry_t head,
	input  wire logic     q_empty,
	output logic          pop,
	output logic          out_valid,
	input  wire logic     out_stall,
	output logic [7:0]    utf8_byte,
	output logic          last_of_run,
	output logic          string_end
);

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       end_q;
	logic [1:0] idx_q;
	logic       load;
	logic       last_byte;

	assign load      = !q_empty && (!out_valid_q || !out_stall);
	assign last_byte = (idx_q == head.nb_m1);
	assign pop       = load && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_byte ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= encode_byte(head.cp, head.nb_m1, idx_q);
			last_q <= last_byte;
			end_q  <= last_byte && head.str_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign utf8_byte   = byte_q;
	assign last_of_run = last_q;
	assign string_end  = end_q;

`ifndef SYNTHESIS
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && end_q |-> last_q)
		else $error("string end flagged on a byte that does not close its run");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> idx_q <= head.nb_m1)
		else $error("byte index ran past the sequence length");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> idx_q == 2'd0)
		else $error("byte index not rewound with an empty queue");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Wide character to UTF-8 encoder testbench
// Drives code units through the encoder in both unit modes and checks
// every output byte, with its flags, against the table or an encoder model.
// ---------------------------------------------------------------------------
// The run starts with a table of directed units: the byte-count boundaries,
// surrogate pairs, a high surrogate at the end of a string, two high
// surrogates in a row, a lone low surrogate, a unit whose used bits are
// zero, the largest 32-bit unit, a mode write that drops a held surrogate
// and a write to an address past the register. Rows whose bytes are obvious
// carry them in the table; the rest go through the model. After that come
// random phases, each in a mode of its own, mostly well-formed text with
// some broken surrogate sequences mixed in. Both sides idle in random
// bursts, except in the second and last phases, which run at full rate.
// ---------------------------------------------------------------------------

module tb_top;
	import wcu8_pkg::*;

	localparam logic [PaddrW-1:0] AddrUnitMode = {RegUnitMode, 2'b00};
	// One word past the last register; writes there must be ignored.
	localparam logic [PaddrW-1:0] AddrSpare    = 3'b100;
	localparam int                RandPhases   = 8;
	localparam int                UnitsPerPhase = 50;
	localparam int                SettleCycles = 8;
	localparam int                MaxReports   = 100;

	// One expected output transaction.
	typedef struct packed {
		logic [7:0] b;
		logic       run_last;
		logic       str_end;
	} utf8_out_t;

	typedef enum logic {RowUnit, RowWrite} row_kind_t;

	// A directed row is either one input transaction or a register write.
	// n_typed < 0 means the bytes come from the model; otherwise the first
	// n_typed bytes of typed, from the top octet down, are the answer.
	typedef struct {
		row_kind_t         kind;
		logic [PaddrW-1:0] addr;
		logic [31:0]       data;
		logic              fin;
		int                n_typed;
		logic [31:0]       typed;
	} stim_row_t;

	localparam int NumDirRows = 29;

	stim_row_t dir_rows [NumDirRows] = '{
		// Byte-count boundaries in 16-bit mode, right after reset.
		'{RowUnit,  AddrUnitMode, 32'h0000_0041, 1'b0,  1, 32'h4100_0000},
		'{RowUnit,  AddrUnitMode, 32'h0000_0001, 1'b1,  1, 32'h0100_0000},
		'{RowUnit,  AddrUnitMode, 32'h0000_007F, 1'b0,  1, 32'h7F00_0000},
		'{RowUnit,  AddrUnitMode, 32'h0000_0080, 1'b0,  2, 32'hC280_0000},
		'{RowUnit,  AddrUnitMode, 32'h0000_07FF, 1'b0,  2, 32'hDFBF_0000},
		'{RowUnit,  AddrUnitMode, 32'h0000_0800, 1'b0,  3, 32'hE0A0_8000},
		'{RowUnit,  AddrUnitMode, 32'h0000_FFFF, 1'b1,  3, 32'hEFBF_BF00},
		// The used half is zero: a plain 0x00 byte that does not end the string.
		'{RowUnit,  AddrUnitMode, 32'hFFFF_0000, 1'b0,  1, 32'h0000_0000},
		// A well-formed pair: the high half is held and gives no byte.
		'{RowUnit,  AddrUnitMode, 32'h0000_D83D, 1'b0,  0, 32'h0000_0000},
		'{RowUnit,  AddrUnitMode, 32'h0000_DE00, 1'b1,  4, 32'hF09F_9880},
		// A high surrogate that ends the string is encoded on its own.
		'{RowUnit,  AddrUnitMode, 32'h0000_DBFF, 1'b1,  3, 32'hEDAF_BF00},
		// Two high surrogates in a row are combined without complaint.
		'{RowUnit,  AddrUnitMode, 32'h0000_D800, 1'b0,  0, 32'h0000_0000},
		'{RowUnit,  AddrUnitMode, 32'h0000_D800, 1'b0, -1, 32'h0000_0000},
		// Held surrogate followed by a unit whose used bits are zero.
		'{RowUnit,  AddrUnitMode, 32'h0000_DBFF, 1'b0,  0, 32'h0000_0000},
		'{RowUnit,  AddrUnitMode, 32'hABCD_0000, 1'b1, -1, 32'h0000_0000},
		// The largest high surrogate with 0xFFFF, which lands past 0x10FFFF.
		'{RowUnit,  AddrUnitMode, 32'h0000_DBFF, 1'b0,  0, 32'h0000_0000},
		'{RowUnit,  AddrUnitMode, 32'h0000_FFFF, 1'b1, -1, 32'h0000_0000},
		// A lone low surrogate is just a three-byte value.
		'{RowUnit,  AddrUnitMode, 32'h0000_DFFF, 1'b0, -1, 32'h0000_0000},
		// Hold a surrogate, then rewrite the mode: the held half must be gone.
		'{RowUnit,  AddrUnitMode, 32'h0000_DABC, 1'b0,  0, 32'h0000_0000},
		'{RowWrite, AddrUnitMode, {31'd0, Mode16}, 1'b0, 0, 32'h0000_0000},
		'{RowUnit,  AddrUnitMode, 32'hFFFF_0042, 1'b1,  1, 32'h4200_0000},
		// 32-bit mode extremes, including a truncated lead byte.
		'{RowWrite, AddrUnitMode, {31'd0, Mode32}, 1'b0, 0, 32'h0000_0000},
		'{RowUnit,  AddrUnitMode, 32'hFFFF_FFFF, 1'b1,  4, 32'hFFBF_BFBF},
		'{RowUnit,  AddrUnitMode, 32'h0010_FFFF, 1'b0,  4, 32'hF48F_BFBF},
		'{RowUnit,  AddrUnitMode, 32'h0000_D800, 1'b0, -1, 32'h0000_0000},
		'{RowUnit,  AddrUnitMode, 32'h0001_0000, 1'b1,  4, 32'hF090_8080},
		// A write past the register leaves 32-bit mode in place.
		'{RowWrite, AddrSpare,    {31'd0, Mode16}, 1'b0, 0, 32'h0000_0000},
		'{RowUnit,  AddrUnitMode, 32'h0000_DBFF, 1'b0, -1, 32'h0000_0000},
		'{RowWrite, AddrUnitMode, {31'd0, Mode16}, 1'b0, 0, 32'h0000_0000}
	};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [PaddrW-1:0] paddr       = '0;
	logic [31:0]       pwdata      = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [31:0]       code_unit   = 32'h0000_0001;
	logic              final_unit  = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [7:0]        utf8_byte;
	logic              last_of_run;
	logic              string_end;

	// Model state: the mode register and the held high surrogate.
	logic              mode_r      = Mode16;
	logic [15:0]       held_hi     = '0;
	logic              hi_pending  = 1'b0;

	utf8_out_t         pending_bytes [$];   // bytes owed by the encoder, oldest first
	utf8_out_t         unit_bytes [$];      // bytes of the unit just accepted
	int                typed_n     = -1;
	logic [31:0]       typed_bytes = '0;
	int                idle_pct    = 0;     // how often either side idles
	int                stall_left  = 0;
	int                mismatch_cnt = 0;

	wide_char_to_utf8_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.utf8_byte  (utf8_byte),
		.last_of_run(last_of_run),
		.string_end (string_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatch_cnt++;
		if (mismatch_cnt <= MaxReports) begin
			$display("%0t ns: mismatch: %s", $time, what);
		end
	endtask

	// Works out the bytes of one accepted unit into unit_bytes and moves the
	// surrogate state along. A held high surrogate yields nothing.
	function automatic void encode_unit(input logic [31:0] unit, input logic fin);
		logic [15:0] u16;
		logic [31:0] cp;
		logic [7:0]  seq [4];
		int          nb;
		utf8_out_t   e;
		u16 = unit[15:0];
		unit_bytes.delete();
		if (mode_r == Mode32) begin
			cp = unit;
		end else if (hi_pending) begin
			// The second half is taken as it comes, even if it is no low
			// surrogate; the sum wraps at 32 bits.
			cp = 32'h0001_0000 + (({16'd0, held_hi} - 32'h0000_D800) << 10)
				+ ({16'd0, u16} - 32'h0000_DC00);
			hi_pending = 1'b0;
			held_hi = '0;
		end else if (u16 >= 16'hD800 && u16 <= 16'hDBFF && !fin) begin
			held_hi = u16;
			hi_pending = 1'b1;
			return;
		end else begin
			cp = {16'd0, u16};
		end
		if (cp < 32'h80) begin
			nb = 1;
			seq[0] = cp[7:0];
		end else if (cp < 32'h800) begin
			nb = 2;
			seq[0] = 8'hC0 | cp[13:6];
			seq[1] = {2'b10, cp[5:0]};
		end else if (cp < 32'h1_0000) begin
			nb = 3;
			seq[0] = 8'hE0 | cp[19:12];
			seq[1] = {2'b10, cp[11:6]};
			seq[2] = {2'b10, cp[5:0]};
		end else begin
			// Past 0x10FFFF the lead byte simply loses its top bits.
			nb = 4;
			seq[0] = 8'hF0 | cp[25:18];
			seq[1] = {2'b10, cp[17:12]};
			seq[2] = {2'b10, cp[11:6]};
			seq[3] = {2'b10, cp[5:0]};
		end
		for (int k = 0; k < nb; k++) begin
			e.b = seq[k];
			e.run_last = (k == nb - 1);
			e.str_end = (k == nb - 1) && fin;
			unit_bytes.insert(unit_bytes.size(), e);
		end
	endfunction

	// Scoreboard. Inputs and outputs are both sampled at the rising edge,
	// before the design's registers move. An accepted unit is queued first;
	// its bytes cannot show up at the same edge, since they pass through the
	// code point queue and the output register.
	always @(posedge clk) begin : scoreboard
		utf8_out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				encode_unit(code_unit, final_unit);
				if (typed_n < 0) begin
					foreach (unit_bytes[i]) begin
						pending_bytes.insert(pending_bytes.size(), unit_bytes[i]);
					end
				end else begin
					for (int k = 0; k < typed_n; k++) begin
						want.b = typed_bytes[31 - 8*k -: 8];
						want.run_last = (k == typed_n - 1);
						want.str_end = (k == typed_n - 1) && final_unit;
						pending_bytes.insert(pending_bytes.size(), want);
					end
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %02h with nothing expected", utf8_byte));
				end else begin
					want = pending_bytes.pop_front();
					if (utf8_byte !== want.b) begin
						report_mismatch($sformatf("utf8_byte %02h, expected %02h",
							utf8_byte, want.b));
					end
					if (last_of_run !== want.run_last) begin
						report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
							last_of_run, want.run_last, want.b));
					end
					if (string_end !== want.str_end) begin
						report_mismatch($sformatf("string_end %b, expected %b on byte %02h",
							string_end, want.str_end, want.b));
					end
				end
			end
		end
	end

	// Receiver back-pressure: stalls come in random bursts. The counter is
	// updated first so out_stall gets a single assignment per edge.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4) begin
			stall_left = $urandom_range(1, 11);
		end
		out_stall <= (stall_left != 0);
	end

	// Presents one unit and holds it until the encoder takes it. Entered and
	// left at a falling edge; valid stays high between back-to-back units.
	task automatic send_unit(input logic [31:0] u, input logic fin);
		logic [31:0] unit;
		int          gap;
		unit = u;
		// A unit is never all zero; the used half may still be.
		if (unit == '0) unit[31] = 1'b1;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= unit;
		final_unit <= fin;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stops sending and waits for the last byte, then for SettleCycles more
	// rising edges before returning at a falling edge.
	task automatic wait_encoder_idle();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		@(negedge clk);
	endtask

	// Register write (setup, then access) followed straight away by a read of
	// the mode register. Entered and left at a falling edge, encoder idle.
	task automatic write_reg(input logic [PaddrW-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == AddrUnitMode) begin
			// Any write of the mode drops a held surrogate, same value or not.
			mode_r = data[0];
			hi_pending = 1'b0;
			held_hi = '0;
		end
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= AddrUnitMode;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {31'd0, mode_r}) begin
			report_mismatch($sformatf("unit_mode reads %08h, expected %0d", prdata, mode_r));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [15:0] bmp_unit();
		case ($urandom_range(0, 3))
			0:       return 16'($urandom_range(0, 16'h7F));
			1:       return 16'($urandom_range(16'h80, 16'h7FF));
			2:       return 16'($urandom_range(16'h800, 16'hFFFF));
			default: return 16'($urandom());
		endcase
	endfunction

	// Sends one random piece of text in the current mode and tells how many
	// units it took.
	task automatic send_text_piece(output int units);
		logic [31:0] rnd;
		logic [15:0] hi;
		logic        fin;
		int          pick;
		rnd = $urandom();
		pick = $urandom_range(0, 99);
		fin = ($urandom_range(0, 3) == 0);
		hi = 16'($urandom_range(16'hD800, 16'hDBFF));
		units = 1;
		if (mode_r == Mode32) begin
			case ($urandom_range(0, 4))
				0:       send_unit($urandom_range(1, 32'h7F), fin);
				1:       send_unit($urandom_range(32'h80, 32'h7FF), fin);
				2:       send_unit($urandom_range(32'h800, 32'hFFFF), fin);
				3:       send_unit($urandom_range(32'h1_0000, 32'h10_FFFF), fin);
				default: send_unit(rnd, fin);
			endcase
		end else if (pick < 55) begin
			// Upper half is random noise the encoder must ignore.
			send_unit({rnd[31:16], bmp_unit()}, fin);
		end else if (pick < 88) begin
			send_unit({rnd[31:16], hi}, 1'b0);
			send_unit({rnd[15:0], 16'($urandom_range(16'hDC00, 16'hDFFF))}, fin);
			units = 2;
		end else begin
			// Broken sequences.
			case ($urandom_range(0, 2))
				0: send_unit({rnd[31:16], hi}, 1'b1);
				1: begin
					send_unit({rnd[31:16], hi}, 1'b0);
					send_unit({rnd[15:0], 16'($urandom())}, fin);
					units = 2;
				end
				default: send_unit({rnd[31:16], 16'($urandom_range(16'hDC00, 16'hDFFF))}, fin);
			endcase
		end
	endtask

	initial begin : stimulus
		int      sent;
		int      n;
		logic    mode;
		int      phase_idle [RandPhases];

		phase_idle = '{30, 0, 60, 30, 15, 60, 30, 0};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table, no idling.
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == RowWrite) begin
				wait_encoder_idle();
				write_reg(dir_rows[r].addr, dir_rows[r].data);
			end else begin
				typed_n = dir_rows[r].n_typed;
				typed_bytes = dir_rows[r].typed;
				send_unit(dir_rows[r].data, dir_rows[r].fin);
				typed_n = -1;
			end
		end

		// Random phases. Each one starts from an idle encoder with a fresh
		// mode write, so the sender pauses until every byte is out.
		for (int ph = 0; ph < RandPhases; ph++) begin
			if (ph == 0) begin
				mode = Mode16;
			end else if (ph == 1) begin
				mode = Mode32;
			end else begin
				mode = 1'($urandom_range(0, 1));
			end
			idle_pct = 0;
			wait_encoder_idle();
			// Only bit 0 lands in the register; the rest is junk.
			write_reg(AddrUnitMode, {31'($urandom()), mode});
			idle_pct = phase_idle[ph];
			sent = 0;
			while (sent < UnitsPerPhase) begin
				send_text_piece(n);
				sent += n;
			end
		end

		in_valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (4 * SettleCycles) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
hw/rtl/wcu8_pkg.sv
hw/rtl/wcu8_front.sv
hw/rtl/wcu8_queue.sv
hw/rtl/wcu8_back.sv
hw/rtl/wide_char_to_utf8_encoder.sv
tb/tb_top.sv
